@@ sv/krt_pkg.sv @@
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table: request and response
// payloads, action and status codes, and the stored record format.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

	// Default number of record slots.
	localparam int DefaultDepth = 64;

	// Fixed field widths.
	localparam int KeyW     = 32;
	localparam int MarkW    = 16;
	localparam int EntriesW = 7;

	// Request actions.
	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_LIST   = 2'd3
	} action_t;

	// Response status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// One request.
	typedef struct packed {
		action_t           action;
		logic [KeyW-1:0]   key;
		logic [MarkW-1:0]  mark_value;
	} req_t;

	// One response.
	typedef struct packed {
		status_t              status;
		logic [KeyW-1:0]      found_key;
		logic [MarkW-1:0]     found_mark;
		logic [EntriesW-1:0]  entries;
		logic                 last;
	} rsp_t;

	// One stored record.
	typedef struct packed {
		logic [KeyW-1:0]  key;
		logic [MarkW-1:0] mark;
	} rec_t;

endpackage

`default_nettype wire

@@ sv/keyed_record_table.sv @@
// Add, search and a missed delete scan one slot per cycle; a delete hit then
// moves each later record down one per cycle before its response is loaded.
// A list reads each record, waits for the registered read data and emits it,
// record by record; a full add or an empty list answers without a store read.
// One request is in flight at a time; the next waits until its last response loads.
// Reset clears the record count and control state only; the store is not swept.
// ----------------------------------------------------------------------------
// keyed_record_table
// Bounded key and mark table kept in insertion order, with add, delete,
// search and list requests served from a store with one read and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table #(
	parameter int DEPTH = krt_pkg::DefaultDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire krt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output krt_pkg::rsp_t      rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	krt_pkg::rec_t rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	krt_pkg::rec_t wr_data;

	// Request sequencer and response register.
	krt_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Record store.
	krt_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

`default_nettype wire

@@ sv/krt_mem.sv @@
// ----------------------------------------------------------------------------
// krt_mem
// Record store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_mem #(
	parameter int DEPTH = krt_pkg::DefaultDepth,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output krt_pkg::rec_t      rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire krt_pkg::rec_t wr_data
);

	krt_pkg::rec_t mem_q [DEPTH];

	// Synchronous write.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Synchronous, registered read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/krt_ctrl.sv @@
// ----------------------------------------------------------------------------
// krt_ctrl
// Request sequencer: scans the record store one slot per cycle, appends,
// shifts records down after a delete, walks the table for a list, and holds
// the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_ctrl #(
	parameter int DEPTH = krt_pkg::DefaultDepth,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// Request channel.
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire krt_pkg::req_t req,
	// Response channel.
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output krt_pkg::rsp_t      rsp,
	// Record store ports.
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  wire krt_pkg::rec_t rd_data,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output krt_pkg::rec_t      wr_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_EMIT,
		S_LIST_RD,
		S_LIST_WAIT
	} state_t;

	state_t                        state_q;
	krt_pkg::action_t              op_q;
	logic [krt_pkg::KeyW-1:0]      key_q;
	logic [krt_pkg::MarkW-1:0]     mark_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 idx_q;
	logic                          rd_pend_s1;
	logic [AW-1:0]                 rd_addr_s1;
	logic                          list_more_q;
	krt_pkg::rsp_t                 res_q;
	logic                          rsp_valid_q;
	krt_pkg::rsp_t                 rsp_q;

	logic req_fire;
	logic out_free;
	logic emit_go;
	logic more_to_read;
	logic scan_match;
	logic scan_done;

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign emit_go   = (state_q == S_EMIT) && out_free;

	// Scan conditions.
	assign more_to_read = (idx_q < count_q);
	assign scan_match   = (state_q == S_SCAN) && rd_pend_s1 && (rd_data.key == key_q);
	assign scan_done    = (state_q == S_SCAN) && !scan_match && !more_to_read;

	// Store read port: one slot per cycle during a scan or shift, one per
	// record during a list.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		case (state_q)
			S_SCAN:    rd_en = !scan_match && more_to_read;
			S_SHIFT:   rd_en = more_to_read;
			S_LIST_RD: rd_en = 1'b1;
			default:   rd_en = 1'b0;
		endcase
	end

	// Store write port: append after a miss on add, or move a record down
	// one slot during a shift.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = '{key: key_q, mark: mark_q};
		if (scan_done && (op_q == krt_pkg::ACT_ADD)) begin
			wr_en = 1'b1;
		end else if ((state_q == S_SHIFT) && rd_pend_s1) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1 - AW'(1);
			wr_data = rd_data;
		end
	end

	// Sequencer state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= krt_pkg::ACT_ADD;
			key_q       <= '0;
			mark_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			rd_pend_s1  <= 1'b0;
			rd_addr_s1  <= '0;
			list_more_q <= 1'b0;
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// Response register loads the pending response, and drains when taken.
			if (emit_go) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= '{status: res_q.status, found_key: res_q.found_key,
					found_mark: res_q.found_mark,
					entries: krt_pkg::EntriesW'(count_q), last: res_q.last};
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q        <= req.action;
						key_q       <= req.key;
						mark_q      <= req.mark_value;
						idx_q       <= '0;
						rd_pend_s1  <= 1'b0;
						list_more_q <= 1'b0;
						if ((req.action == krt_pkg::ACT_ADD) && (count_q >= CW'(DEPTH))) begin
							res_q   <= '{status: krt_pkg::ST_FULL, found_key: req.key,
								found_mark: '0, entries: '0, last: 1'b1};
							state_q <= S_EMIT;
						end else if (req.action == krt_pkg::ACT_LIST) begin
							if (count_q == '0) begin
								res_q   <= '{status: krt_pkg::ST_EMPTY, found_key: '0,
									found_mark: '0, entries: '0, last: 1'b1};
								state_q <= S_EMIT;
							end else begin
								state_q <= S_LIST_RD;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end

				S_SCAN: begin
					if (scan_match) begin
						// Hit: duplicate for add, the record for search or delete.
						rd_pend_s1 <= 1'b0;
						res_q      <= '{status: (op_q == krt_pkg::ACT_ADD) ?
							krt_pkg::ST_DUP : krt_pkg::ST_OK, found_key: rd_data.key,
							found_mark: rd_data.mark, entries: '0, last: 1'b1};
						if (op_q == krt_pkg::ACT_DELETE) begin
							idx_q   <= CW'(rd_addr_s1) + CW'(1);
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_EMIT;
						end
					end else if (more_to_read) begin
						rd_pend_s1 <= 1'b1;
						rd_addr_s1 <= idx_q[AW-1:0];
						idx_q      <= idx_q + CW'(1);
					end else begin
						// Miss: append on add, not found otherwise.
						rd_pend_s1 <= 1'b0;
						if (op_q == krt_pkg::ACT_ADD) begin
							count_q <= count_q + CW'(1);
							res_q   <= '{status: krt_pkg::ST_OK, found_key: key_q,
								found_mark: mark_q, entries: '0, last: 1'b1};
						end else begin
							res_q   <= '{status: krt_pkg::ST_NOTFOUND, found_key: key_q,
								found_mark: '0, entries: '0, last: 1'b1};
						end
						state_q <= S_EMIT;
					end
				end

				S_SHIFT: begin
					if (more_to_read) begin
						rd_pend_s1 <= 1'b1;
						rd_addr_s1 <= idx_q[AW-1:0];
						idx_q      <= idx_q + CW'(1);
					end else begin
						rd_pend_s1 <= 1'b0;
						count_q    <= count_q - CW'(1);
						state_q    <= S_EMIT;
					end
				end

				S_LIST_RD: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_LIST_WAIT;
				end

				S_LIST_WAIT: begin
					res_q       <= '{status: krt_pkg::ST_OK, found_key: rd_data.key,
						found_mark: rd_data.mark, entries: '0, last: (idx_q == count_q)};
					list_more_q <= (idx_q != count_q);
					state_q     <= S_EMIT;
				end

				S_EMIT: begin
					// Hand the pending response over once the register is free.
					if (out_free) begin
						state_q <= list_more_q ? S_LIST_RD : S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ tb/keyed_record_table_tb.sv @@
// ----------------------------------------------------------------------------
// keyed_record_table_tb
// Self-checking bench for the keyed record table. A directed opening walks
// the empty, duplicate, shift-on-delete and list cases. Random add, delete,
// search and list requests then fill the table to capacity, and random phases follow.
// A scoreboard keeps its own copy of the table and checks every response in
// order, while both handshakes idle and stall in random bursts.
// ----------------------------------------------------------------------------
module keyed_record_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Depth        = krt_pkg::DefaultDepth;
	localparam int TotalItems   = 410;
	localparam int QuietTail    = 40;
	localparam int LongHold     = 400;
	localparam int DrainLimit   = 200000;
	localparam int TimeLimitNs  = 25000000;

	// Keeps a shadow copy of the table and the queue of responses it owes.
	class record_scoreboard;
		int unsigned   capacity;
		krt_pkg::rec_t recs[$];
		krt_pkg::rsp_t owed[$];
		int unsigned   mismatches;
		int unsigned   requests;
		int unsigned   responses;
		int unsigned   peak;
		int unsigned   status_count[5];

		function new(int unsigned cap);
			capacity = cap;
		endfunction

		function void owe(krt_pkg::status_t s, logic [krt_pkg::KeyW-1:0] k,
			logic [krt_pkg::MarkW-1:0] m, bit lst);
			krt_pkg::rsp_t e;
			e.status     = s;
			e.found_key  = k;
			e.found_mark = m;
			e.entries    = krt_pkg::EntriesW'(recs.size());
			e.last       = lst;
			owed.push_back(e);
		endfunction

		// Apply one accepted request to the shadow table and queue its responses.
		function void note_request(krt_pkg::req_t q);
			int            slot;
			krt_pkg::rec_t hit;
			slot = -1;
			requests++;
			foreach (recs[i])
				if (slot < 0 && recs[i].key == q.key)
					slot = i;
			case (q.action)
				krt_pkg::ACT_ADD: begin
					// The capacity check comes before the duplicate check.
					if (recs.size() >= capacity) begin
						owe(krt_pkg::ST_FULL, q.key, '0, 1'b1);
					end else if (slot >= 0) begin
						owe(krt_pkg::ST_DUP, recs[slot].key, recs[slot].mark, 1'b1);
					end else begin
						hit.key  = q.key;
						hit.mark = q.mark_value;
						recs.push_back(hit);
						owe(krt_pkg::ST_OK, q.key, q.mark_value, 1'b1);
					end
				end
				krt_pkg::ACT_DELETE: begin
					if (slot < 0) begin
						owe(krt_pkg::ST_NOTFOUND, q.key, '0, 1'b1);
					end else begin
						hit = recs[slot];
						recs.delete(slot);
						owe(krt_pkg::ST_OK, hit.key, hit.mark, 1'b1);
					end
				end
				krt_pkg::ACT_SEARCH: begin
					if (slot < 0)
						owe(krt_pkg::ST_NOTFOUND, q.key, '0, 1'b1);
					else
						owe(krt_pkg::ST_OK, recs[slot].key, recs[slot].mark, 1'b1);
				end
				default: begin
					if (recs.size() == 0)
						owe(krt_pkg::ST_EMPTY, '0, '0, 1'b1);
					else
						foreach (recs[i])
							owe(krt_pkg::ST_OK, recs[i].key, recs[i].mark,
								i == recs.size() - 1);
				end
			endcase
			if (recs.size() > peak)
				peak = recs.size();
		endfunction

		// Compare one accepted response with the oldest owed one.
		function void check_result(krt_pkg::rsp_t r);
			krt_pkg::rsp_t e;
			bit            bad;
			responses++;
			if (int'(r.status) < 5)
				status_count[int'(r.status)]++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("  %0t: unexpected response: status %0d key %h mark %h",
						$time, r.status, r.found_key, r.found_mark);
				return;
			end
			e = owed.pop_front();
			bad = (r.status !== e.status) || (r.found_key !== e.found_key) ||
				(r.found_mark !== e.found_mark) || (r.entries !== e.entries) ||
				(r.last !== e.last);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("  %0t: expected status %0d key %h mark %h entries %0d last %0d",
						$time, e.status, e.found_key, e.found_mark, e.entries, e.last);
					$display("  %0t:      got status %0d key %h mark %h entries %0d last %0d",
						$time, r.status, r.found_key, r.found_mark, r.entries, r.last);
				end
			end
		endfunction

		function int unsigned outstanding();
			return owed.size();
		endfunction

		// Anything still owed at the end counts against the run.
		function void close();
			if (owed.size() != 0) begin
				$display("  %0d responses never arrived", owed.size());
				mismatches += owed.size();
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	krt_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	krt_pkg::rsp_t rsp;

	record_scoreboard sb = new(Depth);
	bit          quiet;
	bit          hold_off;
	int unsigned long_holds;
	int unsigned sent;

	keyed_record_table #(.DEPTH(Depth)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check every accepted response.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
	end

	// Response side: random stall bursts, one long hold-off on demand.
	initial begin
		int len;
		rsp_stall = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				long_holds++;
				rsp_stall <= 1'b1;
				len = LongHold;
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				rsp_stall <= 1'b1;
				len = $urandom_range(1, 13);
			end else begin
				rsp_stall <= 1'b0;
				len = $urandom_range(1, 20);
			end
			repeat (len) @(posedge clk);
		end
	end

	// Offer one request and hold it until it is taken.
	task automatic send_request(krt_pkg::req_t q);
		req       <= q;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(q);
		sent++;
	endtask

	task automatic idle_gap(int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Send a request, sometimes followed by an idle burst.
	task automatic request(krt_pkg::action_t a, logic [krt_pkg::KeyW-1:0] k,
		logic [krt_pkg::MarkW-1:0] m);
		krt_pkg::req_t q;
		q.action     = a;
		q.key        = k;
		q.mark_value = m;
		send_request(q);
		if (!quiet && $urandom_range(0, 4) == 0)
			idle_gap($urandom_range(1, 13));
	endtask

	// Stop offering requests until every owed response has come back.
	task automatic drain_pause();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	// A stored key with the given chance in percent, else corner or random keys.
	function automatic logic [krt_pkg::KeyW-1:0] pick_key(int unsigned hit_pct);
		int unsigned               sel;
		logic [krt_pkg::KeyW-1:0]  corner_keys[5];
		corner_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
			32'h8000_0000, 32'h7FFF_FFFF};
		sel = $urandom_range(0, 99);
		if (sel < hit_pct && sb.recs.size() != 0)
			return sb.recs[$urandom_range(0, sb.recs.size() - 1)].key;
		if (sel >= 90)
			return corner_keys[$urandom_range(0, 4)];
		return $urandom();
	endfunction

	function automatic logic [krt_pkg::MarkW-1:0] pick_mark();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return krt_pkg::MarkW'($urandom_range(0, 65535));
		endcase
	endfunction

	// One random request with the given mix of actions, in percent.
	task automatic random_request(int add_pct, int del_pct, int srch_pct);
		int               sel;
		krt_pkg::action_t a;
		sel = $urandom_range(0, 99);
		if (sel < add_pct)
			a = krt_pkg::ACT_ADD;
		else if (sel < add_pct + del_pct)
			a = krt_pkg::ACT_DELETE;
		else if (sel < add_pct + del_pct + srch_pct)
			a = krt_pkg::ACT_SEARCH;
		else
			a = krt_pkg::ACT_LIST;
		request(a, pick_key(a == krt_pkg::ACT_ADD ? 10 : 75), pick_mark());
	endtask

	// Main sequence.
	initial begin
		int phase_kind;
		int phase_len;
		int waited;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (!arst_n);

		// Directed: empty table, duplicates, shifts at front, middle and end.
		request(krt_pkg::ACT_LIST,   32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_SEARCH, 32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_DELETE, 32'hFFFF_FFFF, 16'hFFFF);
		request(krt_pkg::ACT_ADD,    32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_ADD,    32'hFFFF_FFFF, 16'hFFFF);
		request(krt_pkg::ACT_ADD,    32'h0000_0000, 16'h1234);
		request(krt_pkg::ACT_ADD,    32'h8000_0000, 16'h8000);
		request(krt_pkg::ACT_ADD,    32'h1234_5678, 16'h0001);
		request(krt_pkg::ACT_SEARCH, 32'hFFFF_FFFF, 16'h0000);
		request(krt_pkg::ACT_SEARCH, 32'h0000_0005, 16'h0000);
		request(krt_pkg::ACT_LIST,   32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_DELETE, 32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_DELETE, 32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_DELETE, 32'h1234_5678, 16'h0000);
		request(krt_pkg::ACT_LIST,   32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_ADD,    32'h0000_0000, 16'hFFFF);
		request(krt_pkg::ACT_SEARCH, 32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_DELETE, 32'h8000_0000, 16'h0000);
		request(krt_pkg::ACT_LIST,   32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_DELETE, 32'hFFFF_FFFF, 16'h0000);
		request(krt_pkg::ACT_DELETE, 32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_LIST,   32'hFFFF_FFFF, 16'hFFFF);
		drain_pause();

		// Fill the table to capacity, then knock on a full table.
		while (sb.recs.size() < Depth)
			random_request(85, 3, 7);
		request(krt_pkg::ACT_ADD, $urandom(), pick_mark());
		request(krt_pkg::ACT_ADD, pick_key(100), pick_mark());

		// Long response hold-off while requests keep coming on a full table.
		hold_off = 1'b1;
		request(krt_pkg::ACT_SEARCH, pick_key(100), 16'h0000);
		request(krt_pkg::ACT_LIST,   32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_ADD,    32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_SEARCH, $urandom(), 16'h0000);
		request(krt_pkg::ACT_LIST,   32'h0000_0000, 16'h0000);
		request(krt_pkg::ACT_DELETE, pick_key(100), 16'h0000);
		request(krt_pkg::ACT_SEARCH, pick_key(100), 16'h0000);
		drain_pause();

		// Random phases: add-heavy, delete-heavy and mixed.
		while (sent < TotalItems) begin
			phase_kind = $urandom_range(0, 2);
			phase_len  = $urandom_range(15, 40);
			for (int i = 0; i < phase_len && sent < TotalItems; i++) begin
				if (sent >= TotalItems - QuietTail)
					quiet = 1'b1;
				case (phase_kind)
					0:       random_request(70, 10, 15);
					1:       random_request(10, 65, 20);
					default: random_request(35, 25, 30);
				endcase
			end
			if ($urandom_range(0, 2) == 0)
				drain_pause();
		end

		// Wait for the last responses, then let the block settle.
		req_valid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (sb.outstanding() != 0 && waited < DrainLimit);
		repeat (Depth * 4 + 16) @(posedge clk);
		sb.close();

		$display("Run: %0d requests, %0d responses, table peaked at %0d of %0d records.",
			sb.requests, sb.responses, sb.peak, Depth);
		$display("Statuses seen: ok %0d, full %0d, duplicate %0d, not found %0d,",
			sb.status_count[0], sb.status_count[1], sb.status_count[2],
			sb.status_count[3]);
		$display("  empty %0d; %0d long hold-off.", sb.status_count[4], long_holds);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hard stop if the run hangs.
	initial begin
		#(TimeLimitNs);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ keyed_record_table.f @@
sv/krt_pkg.sv
sv/krt_mem.sv
sv/krt_ctrl.sv
sv/keyed_record_table.sv
tb/keyed_record_table_tb.sv
